@@ rtl/square_fill_collision_engine_assert.svh @@
// Assertion macros for the square fill and collision engine.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef SQUARE_FILL_COLLISION_ENGINE_ASSERT_SVH
`define SQUARE_FILL_COLLISION_ENGINE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SFCE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfce: implication check failed");
`define SFCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfce: next-cycle check failed");
`else
`define SFCE_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SFCE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/sfce_pkg.sv @@
// Package for the square fill and collision engine: request/response types,
// mode and status codes, default frame size. No dependencies.
package sfce_pkg;

   localparam int unsigned FRAME_W_DEFAULT = 64;
   localparam int unsigned FRAME_H_DEFAULT = 64;

   localparam int COORD_W = 6;
   localparam int SIDE_W  = 7;
   localparam int COLOR_W = 32;
   localparam int SUM_W   = 8;

   localparam logic [COLOR_W-1:0] BG_RESET = '0;

   localparam logic [1:0] MODE_DRAW  = 2'd0;
   localparam logic [1:0] MODE_ERASE = 2'd1;
   localparam logic [1:0] MODE_CHECK = 2'd2;
   localparam logic [1:0] MODE_READ  = 2'd3;

   localparam logic [1:0] STATUS_OK  = 2'd0;
   localparam logic [1:0] STATUS_OOB = 2'd1;
   localparam logic [1:0] STATUS_HIT = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic [COORD_W-1:0] corner_x;
      logic [COORD_W-1:0] corner_y;
      logic [SIDE_W-1:0]  side;
      logic [COLOR_W-1:0] color;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [COORD_W-1:0] hit_x;
      logic [COORD_W-1:0] hit_y;
      logic [COLOR_W-1:0] pixel;
   } rsp_type;

endpackage

@@ rtl/sfce_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sfce_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/square_fill_collision_engine.sv @@
// Square fill and collision engine; needs sfce_pkg, sfce_ram and the assertion macro header.
// Draw/erase write one pixel per frame RAM cycle; check reads at that rate, stopping at the
// first non-background pixel; read fetches a pixel; out of bounds or zero side skip the RAM.
// One request at a time: the next is accepted in the cycle the previous response is raised
// (it may still be waiting), so each request is finished before the next is taken.
// Sync reset; then a clearing pass writes BG_RESET to every frame pixel with req_ready low.
`include "square_fill_collision_engine_assert.svh"

module square_fill_collision_engine #(
   parameter int unsigned FRAME_W = sfce_pkg::FRAME_W_DEFAULT,
   parameter int unsigned FRAME_H = sfce_pkg::FRAME_H_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  sfce_pkg::req_type                  req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output sfce_pkg::rsp_type                  rsp_payload,
   input  logic                               csr_write_en,
   input  logic [sfce_pkg::COLOR_W-1:0]       csr_write_data
);

   localparam int unsigned DEPTH = FRAME_W * FRAME_H;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);
   localparam int SW = sfce_pkg::SUM_W;
   localparam int CW = sfce_pkg::COORD_W;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_FILL  = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_READ  = 3'd4;
   localparam logic [2:0] S_RDATA = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0]                       state_ff, state_in;
   logic [AW-1:0]                    addr_ff, addr_in;
   logic [AW-1:0]                    col_step_ff, col_step_in;
   logic [SW-1:0]                    cur_x_ff, cur_x_in;
   logic [SW-1:0]                    cur_y_ff, cur_y_in;
   logic [SW-1:0]                    y0_ff, y0_in;
   logic [SW-1:0]                    x_last_ff, x_last_in;
   logic [SW-1:0]                    y_last_ff, y_last_in;
   logic [SW-1:0]                    rd_x_ff, rd_x_in;
   logic [SW-1:0]                    rd_y_ff, rd_y_in;
   logic [sfce_pkg::COLOR_W-1:0]     fill_ff, fill_in;
   logic [sfce_pkg::COLOR_W-1:0]     bg_ff, bg_in;
   logic                             issuing_ff, issuing_in;
   logic                             rd_valid_ff, rd_valid_in;
   sfce_pkg::rsp_type                res_ff, res_in;
   sfce_pkg::rsp_type                rsp_ff, rsp_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   logic                             mem_we, mem_re;
   logic [sfce_pkg::COLOR_W-1:0]     mem_wdata, mem_rdata;

   logic [SW-1:0]                    x_end, y_end;
   logic                             fits, pix_in;
   logic                             step, last_pix, col_end, rd_hit;

   assign x_end   = SW'(req_payload.corner_x) + SW'(req_payload.side);
   assign y_end   = SW'(req_payload.corner_y) + SW'(req_payload.side);
   assign fits    = (32'(x_end) <= FRAME_W) && (32'(y_end) <= FRAME_H);
   assign pix_in  = (32'(req_payload.corner_x) < FRAME_W) &&
                    (32'(req_payload.corner_y) < FRAME_H);
   assign col_end  = (cur_y_ff == y_last_ff);
   assign last_pix = col_end && (cur_x_ff == x_last_ff);
   assign rd_hit   = rd_valid_ff && (mem_rdata != bg_ff);

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      col_step_in  = col_step_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      y0_in        = y0_ff;
      x_last_in    = x_last_ff;
      y_last_in    = y_last_ff;
      rd_x_in      = cur_x_ff;
      rd_y_in      = cur_y_ff;
      fill_in      = fill_ff;
      issuing_in   = issuing_ff;
      rd_valid_in  = 1'b0;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      bg_in        = csr_write_en ? csr_write_data : bg_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      step         = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            mem_we  = 1'b1;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == ADDR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cur_x_in    = SW'(req_payload.corner_x);
               cur_y_in    = SW'(req_payload.corner_y);
               y0_in       = SW'(req_payload.corner_y);
               x_last_in   = x_end - 1'b1;
               y_last_in   = y_end - 1'b1;
               addr_in     = AW'(32'(req_payload.corner_x) * FRAME_H +
                                 32'(req_payload.corner_y));
               col_step_in = AW'(FRAME_H + 1 - 32'(req_payload.side));
               fill_in     = (req_payload.mode == sfce_pkg::MODE_DRAW) ?
                             req_payload.color : bg_ff;
               issuing_in  = 1'b1;
               res_in      = '0;
               if (req_payload.mode == sfce_pkg::MODE_READ) begin
                  if (pix_in) begin
                     state_in = S_READ;
                  end else begin
                     res_in.status = sfce_pkg::STATUS_OOB;
                     state_in      = S_DONE;
                  end
               end else if (!fits) begin
                  res_in.status = sfce_pkg::STATUS_OOB;
                  state_in      = S_DONE;
               end else if (req_payload.side == '0) begin
                  state_in = S_DONE;
               end else if (req_payload.mode == sfce_pkg::MODE_CHECK) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_FILL;
               end
            end
         end
         S_FILL: begin
            mem_we = 1'b1;
            step   = 1'b1;
            if (last_pix) begin
               state_in = S_DONE;
            end
         end
         S_SCAN: begin
            if (rd_hit) begin
               res_in.status = sfce_pkg::STATUS_HIT;
               res_in.hit_x  = rd_x_ff[CW-1:0];
               res_in.hit_y  = rd_y_ff[CW-1:0];
               state_in      = S_DONE;
            end else if (issuing_ff) begin
               mem_re      = 1'b1;
               step        = 1'b1;
               rd_valid_in = 1'b1;
               if (last_pix) begin
                  issuing_in = 1'b0;
               end
            end else if (!rd_valid_ff) begin
               state_in = S_DONE;
            end
         end
         S_READ: begin
            mem_re   = 1'b1;
            state_in = S_RDATA;
         end
         S_RDATA: begin
            res_in.pixel = mem_rdata;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (step) begin
         if (col_end) begin
            cur_y_in = y0_ff;
            cur_x_in = cur_x_ff + 1'b1;
            addr_in  = addr_ff + col_step_ff;
         end else begin
            cur_y_in = cur_y_ff + 1'b1;
            addr_in  = addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         addr_ff      <= '0;
         issuing_ff   <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bg_ff        <= sfce_pkg::BG_RESET;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         issuing_ff   <= issuing_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         bg_ff        <= bg_in;
      end
   end

   always_ff @(posedge clock) begin
      col_step_ff <= col_step_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      y0_ff       <= y0_in;
      x_last_ff   <= x_last_in;
      y_last_ff   <= y_last_in;
      rd_x_ff     <= rd_x_in;
      rd_y_ff     <= rd_y_in;
      fill_ff     <= fill_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   assign mem_wdata = (state_ff == S_CLEAR) ? sfce_pkg::BG_RESET : fill_ff;

   sfce_ram #(
      .WIDTH (sfce_pkg::COLOR_W),
      .DEPTH (DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (addr_ff),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (addr_ff),
      .rd_data (mem_rdata)
   );

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `SFCE_ASSERT_IMPLY(a_write_only_clear_fill, clock, reset, mem_we,
      (state_ff == S_CLEAR) || (state_ff == S_FILL))
   `SFCE_ASSERT_NEXT(a_clear_once, clock, reset, state_ff != S_CLEAR, state_ff != S_CLEAR)
   `SFCE_ASSERT_IMPLY(a_pending_read_in_scan, clock, reset, rd_valid_ff, state_ff == S_SCAN)
   `SFCE_ASSERT_IMPLY(a_oob_clean, clock, reset,
      rsp_valid_ff && (rsp_ff.status == sfce_pkg::STATUS_OOB),
      (rsp_ff.pixel == '0) && (rsp_ff.hit_x == '0) && (rsp_ff.hit_y == '0))

endmodule
